// ----- hw/rtl/tflc_pkg.sv -----
// shared types, codes and constants of the tic frame line checker
package tflc_pkg;

	// default sizes of the line store and the token limits
	localparam int LINE_BYTES_DEF = 128;
	localparam int LABEL_MAX_DEF  = 31;
	localparam int VALUE_MAX_DEF  = 63;

	// control characters
	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_STX = 8'h02;
	localparam logic [7:0] CHAR_ETX = 8'h03;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_VT  = 8'h0B;
	localparam logic [7:0] CHAR_FF  = 8'h0C;
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_SP  = 8'h20;

	// offset that turns the 6-bit sum into a printable character
	localparam logic [6:0] CHECK_BIAS = 7'h20;

	// byte roles
	localparam logic [2:0] ROLE_IGNORED  = 3'd0;
	localparam logic [2:0] ROLE_FRAME_ST = 3'd1;
	localparam logic [2:0] ROLE_FRAME_END = 3'd2;
	localparam logic [2:0] ROLE_LABEL    = 3'd3;
	localparam logic [2:0] ROLE_VALUE    = 3'd4;
	localparam logic [2:0] ROLE_CHECK    = 3'd5;
	localparam logic [2:0] ROLE_SPACE    = 3'd6;
	localparam logic [2:0] ROLE_LINE_END = 3'd7;

	// line verdicts
	localparam logic [1:0] VERD_NONE      = 2'd0;
	localparam logic [1:0] VERD_OK        = 2'd1;
	localparam logic [1:0] VERD_BAD       = 2'd2;
	localparam logic [1:0] VERD_MALFORMED = 2'd3;

	// configuration registers
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRAILING  = 1'd1;
	localparam logic [6:0] SEPARATOR_RESET = 7'd32;
	localparam logic       TRAILING_RESET  = 1'b1;

	// input word
	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_word_t;

	// result word
	typedef struct packed {
		logic [7:0] byte_echo;
		logic [2:0] byte_role;
		logic [1:0] verdict;
		logic [6:0] computed_check;
		logic [7:0] received_check;
	} res_word_t;

endpackage

// ----- hw/rtl/tflc_stream_if.sv -----
// valid/ready stream channel carrying one word per handshake
interface tflc_stream_if #(
	parameter type payload_t = tflc_pkg::rx_word_t
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/tic_frame_line_checker_top.sv -----
// tic frame line checker: tags each received byte and checks line checksums
//
// Channels: rx (sink) takes one received character per word; result (source)
// gives one word per input word with the byte echoed, its role, the verdict at
// a line end, the checksum computed so far and the checksum character taken.
// The configuration port writes the separator code (index 0) and the
// trailing-separator switch (index 1) at any edge with cfg_we high.
// Path: a word accepted on rx sits in the input register, passes the
// line-state update into the result register and is offered on result
// from then on.
// Throughput: one word per cycle unless result stalls; the line state is
// a few counters and a 6-bit sum updated by one add per byte, so nothing loops.
// Reset: arst_n clears the pipeline, closes the frame, clears the line state
// and loads separator 32 with the trailing separator on.
// Stall: while result is not taken the result register holds, the input
// register fills and rx.ready drops; it rises again in the cycle the receiver
// takes the waiting word.
module tic_frame_line_checker_top #(
	parameter int LINE_BYTES = tflc_pkg::LINE_BYTES_DEF,
	parameter int LABEL_MAX  = tflc_pkg::LABEL_MAX_DEF,
	parameter int VALUE_MAX  = tflc_pkg::VALUE_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tflc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tflc_pkg::CFG_DATA_W-1:0] cfg_data,
	tflc_stream_if.sink                     rx,
	tflc_stream_if.source                   result
);
	import tflc_pkg::*;

	localparam int CNT_W = $clog2(LINE_BYTES);
	localparam int LBL_W = $clog2(LABEL_MAX + 1);
	localparam int VAL_W = $clog2(VALUE_MAX + 1);

	typedef enum logic [2:0] {
		PH_BEFORE,
		PH_LABEL,
		PH_GAP_LABEL,
		PH_VALUE,
		PH_GAP_VALUE,
		PH_DONE
	} phase_t;

	// configuration registers
	logic [6:0] sep_q;
	logic       trail_q;

	// pipeline registers
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	res_word_t  res_s2;

	// line state
	logic             frame_q;
	phase_t           phase_q;
	logic [5:0]       sum_q;
	logic [CNT_W-1:0] stored_q;
	logic [LBL_W-1:0] lbl_q;
	logic [VAL_W-1:0] val_q;
	logic [7:0]       check_q;
	logic             ovf_q;
	logic             nul_q;
	logic             chk_q;

	// next line state
	logic             frame_d;
	phase_t           phase_d;
	logic [5:0]       sum_d;
	logic [CNT_W-1:0] stored_d;
	logic [LBL_W-1:0] lbl_d;
	logic [VAL_W-1:0] val_d;
	logic [7:0]       check_d;
	logic             ovf_d;
	logic             nul_d;
	logic             chk_d;
	res_word_t        res_d;

	logic       adv;
	logic [5:0] sep_sum;
	logic [6:0] check_now;
	logic [5:0] sum_out;
	logic       ws;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q   <= SEPARATOR_RESET;
			trail_q <= TRAILING_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SEPARATOR: sep_q   <= cfg_data;
				CFG_TRAILING:  trail_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake: the result register frees when empty or taken
	assign adv             = !valid_s2 || result.ready;
	assign rx.ready        = !valid_s1 || adv;
	assign result.valid    = valid_s2;
	assign result.payload  = res_s2;

	// separators' share of the sum
	assign sep_sum   = sep_q[5:0] + (trail_q ? sep_q[5:0] : 6'd0);
	assign check_now = {1'b0, 6'(sum_q + sep_sum)} + CHECK_BIAS;

	assign ws = (byte_s1 == CHAR_SP) || (byte_s1 == CHAR_TAB) ||
		(byte_s1 == CHAR_VT) || (byte_s1 == CHAR_FF);

	// line-state update and result for the byte in the input register
	always_comb begin
		frame_d  = frame_q;
		phase_d  = phase_q;
		sum_d    = sum_q;
		stored_d = stored_q;
		lbl_d    = lbl_q;
		val_d    = val_q;
		check_d  = check_q;
		ovf_d    = ovf_q;
		nul_d    = nul_q;
		chk_d    = chk_q;
		sum_out  = sum_q;
		res_d.byte_echo      = byte_s1;
		res_d.byte_role      = ROLE_IGNORED;
		res_d.verdict        = VERD_NONE;
		res_d.computed_check = check_now;
		res_d.received_check = check_q;

		if (byte_s1 == CHAR_STX) begin
			frame_d         = 1'b1;
			phase_d         = PH_BEFORE;
			sum_d           = '0;
			stored_d        = '0;
			lbl_d           = '0;
			val_d           = '0;
			check_d         = '0;
			ovf_d           = 1'b0;
			nul_d           = 1'b0;
			chk_d           = 1'b0;
			res_d.byte_role = ROLE_FRAME_ST;
		end else if (byte_s1 == CHAR_ETX) begin
			frame_d         = 1'b0;
			res_d.byte_role = ROLE_FRAME_END;
		end else if (!frame_q || byte_s1 == CHAR_CR) begin
			res_d.byte_role = ROLE_IGNORED;
		end else if (byte_s1 == CHAR_LF) begin
			res_d.byte_role = ROLE_LINE_END;
			if (ovf_q || !chk_q) begin
				res_d.verdict = VERD_MALFORMED;
			end else if ({1'b0, check_now} == check_q) begin
				res_d.verdict = VERD_OK;
			end else begin
				res_d.verdict = VERD_BAD;
			end
		end else if (stored_q < CNT_W'(LINE_BYTES - 1)) begin
			stored_d = stored_q + CNT_W'(1);
			if (nul_q) begin
				res_d.byte_role = ROLE_SPACE;
			end else if (byte_s1 == CHAR_NUL) begin
				nul_d           = 1'b1;
				res_d.byte_role = ROLE_SPACE;
			end else begin
				case (phase_q)
					PH_BEFORE, PH_LABEL: begin
						if (ws) begin
							if (phase_q == PH_LABEL) phase_d = PH_GAP_LABEL;
							res_d.byte_role = ROLE_SPACE;
						end else begin
							phase_d         = PH_LABEL;
							res_d.byte_role = ROLE_LABEL;
							if (lbl_q < LBL_W'(LABEL_MAX)) begin
								sum_d = sum_q + byte_s1[5:0];
								lbl_d = lbl_q + LBL_W'(1);
							end else begin
								ovf_d = 1'b1;
							end
						end
					end
					PH_GAP_LABEL, PH_VALUE: begin
						if (ws) begin
							if (phase_q == PH_VALUE) phase_d = PH_GAP_VALUE;
							res_d.byte_role = ROLE_SPACE;
						end else begin
							phase_d         = PH_VALUE;
							res_d.byte_role = ROLE_VALUE;
							if (val_q < VAL_W'(VALUE_MAX)) begin
								sum_d = sum_q + byte_s1[5:0];
								val_d = val_q + VAL_W'(1);
							end else begin
								ovf_d = 1'b1;
							end
						end
					end
					PH_GAP_VALUE: begin
						if (ws) begin
							res_d.byte_role = ROLE_SPACE;
						end else begin
							check_d         = byte_s1;
							chk_d           = 1'b1;
							phase_d         = PH_DONE;
							res_d.byte_role = ROLE_CHECK;
						end
					end
					default: res_d.byte_role = ROLE_SPACE;
				endcase
			end
		end else begin
			res_d.byte_role = ROLE_IGNORED;
		end

		// checksum and received character after this byte
		sum_out              = sum_d;
		res_d.computed_check = {1'b0, 6'(sum_out + sep_sum)} + CHECK_BIAS;
		res_d.received_check = check_d;

		// a line end clears the line once its word is formed
		if (res_d.byte_role == ROLE_LINE_END) begin
			phase_d  = PH_BEFORE;
			sum_d    = '0;
			stored_d = '0;
			lbl_d    = '0;
			val_d    = '0;
			check_d  = '0;
			ovf_d    = 1'b0;
			nul_d    = 1'b0;
			chk_d    = 1'b0;
		end
	end

	// pipeline control and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			frame_q  <= 1'b0;
			phase_q  <= PH_BEFORE;
			sum_q    <= '0;
			stored_q <= '0;
			lbl_q    <= '0;
			val_q    <= '0;
			check_q  <= '0;
			ovf_q    <= 1'b0;
			nul_q    <= 1'b0;
			chk_q    <= 1'b0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					frame_q  <= frame_d;
					phase_q  <= phase_d;
					sum_q    <= sum_d;
					stored_q <= stored_d;
					lbl_q    <= lbl_d;
					val_q    <= val_d;
					check_q  <= check_d;
					ovf_q    <= ovf_d;
					nul_q    <= nul_d;
					chk_q    <= chk_d;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.payload.rx_byte;
		end
		if (adv && valid_s1) begin
			res_s2 <= res_d;
		end
	end

`ifndef SYNTHESIS
	// a verdict is given on a line end and only there
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.byte_role == ROLE_LINE_END |-> res_s2.verdict != VERD_NONE)
		else $error("line end without verdict");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.verdict != VERD_NONE |-> res_s2.byte_role == ROLE_LINE_END)
		else $error("verdict outside a line end");

	// computed checksum is always a printable character
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> res_s2.computed_check[6:5] == 2'b01 ||
			res_s2.computed_check[6:5] == 2'b10)
		else $error("computed checksum out of range");

	// a frame start leaves a cleared line
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.byte_role == ROLE_FRAME_ST |-> res_s2.received_check == 8'd0)
		else $error("frame start did not clear the line");

	// the stored count stays within the line store
	assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= CNT_W'(LINE_BYTES - 1))
		else $error("stored count beyond line store");
`endif

endmodule

// ----- tb/tflc_result_checker.sv -----
// result checker of the tic frame line checker: predicts each result word and compares
module tflc_result_checker #(
	parameter int LINE_BYTES = tflc_pkg::LINE_BYTES_DEF,
	parameter int LABEL_MAX  = tflc_pkg::LABEL_MAX_DEF,
	parameter int VALUE_MAX  = tflc_pkg::VALUE_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tflc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tflc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            rx_valid,
	input  logic                            rx_ready,
	input  tflc_pkg::rx_word_t              rx_payload,
	input  logic                            res_valid,
	input  logic                            res_ready,
	input  tflc_pkg::res_word_t             res_payload,
	output int                              mismatches,
	output int                              outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import tflc_pkg::*;

	typedef enum logic [2:0] {
		TOK_BEFORE_LABEL,
		TOK_LABEL,
		TOK_LABEL_GAP,
		TOK_VALUE,
		TOK_VALUE_GAP,
		TOK_AFTER_CHECK
	} tok_phase_t;

	// own copy of the registers and of the line state
	logic [6:0] sep_code;
	logic       trail_on;
	logic       frame_open;
	tok_phase_t tok_phase;
	logic [5:0] sum6;
	int         stored;
	int         label_len;
	int         value_len;
	logic [7:0] chk_char;
	logic       overflow;
	logic       nul_seen;
	logic       chk_taken;

	res_word_t expected_words[$];

	function automatic void clear_line();
		tok_phase = TOK_BEFORE_LABEL;
		sum6 = '0;
		stored = 0;
		label_len = 0;
		value_len = 0;
		chk_char = '0;
		overflow = 1'b0;
		nul_seen = 1'b0;
		chk_taken = 1'b0;
	endfunction

	// checksum character over the line as it stands
	function automatic logic [6:0] line_check();
		logic [7:0] s;
		s = {2'b00, sum6} + {1'b0, sep_code};
		if (trail_on) begin
			s = s + {1'b0, sep_code};
		end
		return {1'b0, s[5:0]} + CHECK_BIAS;
	endfunction

	// label or value character: summed while the token is within its limit
	function automatic void keep_char(input logic [7:0] c, input logic in_label);
		if (in_label ? (label_len < LABEL_MAX) : (value_len < VALUE_MAX)) begin
			sum6 = sum6 + c[5:0];
			if (in_label) begin
				label_len++;
			end else begin
				value_len++;
			end
		end else begin
			overflow = 1'b1;
		end
	endfunction

	// role of a stored byte, moving through label, value and checksum tokens
	function automatic logic [2:0] token_role(input logic [7:0] c);
		logic ws;
		ws = (c == CHAR_SP) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
		if (nul_seen) begin
			return ROLE_SPACE;
		end
		if (c == CHAR_NUL) begin
			nul_seen = 1'b1;
			return ROLE_SPACE;
		end
		case (tok_phase)
			TOK_BEFORE_LABEL: begin
				if (ws) return ROLE_SPACE;
				tok_phase = TOK_LABEL;
				keep_char(c, 1'b1);
				return ROLE_LABEL;
			end
			TOK_LABEL: begin
				if (ws) begin
					tok_phase = TOK_LABEL_GAP;
					return ROLE_SPACE;
				end
				keep_char(c, 1'b1);
				return ROLE_LABEL;
			end
			TOK_LABEL_GAP: begin
				if (ws) return ROLE_SPACE;
				tok_phase = TOK_VALUE;
				keep_char(c, 1'b0);
				return ROLE_VALUE;
			end
			TOK_VALUE: begin
				if (ws) begin
					tok_phase = TOK_VALUE_GAP;
					return ROLE_SPACE;
				end
				keep_char(c, 1'b0);
				return ROLE_VALUE;
			end
			TOK_VALUE_GAP: begin
				if (ws) return ROLE_SPACE;
				chk_char = c;
				chk_taken = 1'b1;
				tok_phase = TOK_AFTER_CHECK;
				return ROLE_CHECK;
			end
			default: return ROLE_SPACE;
		endcase
	endfunction

	// expected result word for one received byte
	function automatic res_word_t tag_byte(input logic [7:0] c);
		res_word_t r;
		r.byte_echo = c;
		r.byte_role = ROLE_IGNORED;
		r.verdict = VERD_NONE;
		if (c == CHAR_STX) begin
			frame_open = 1'b1;
			clear_line();
			r.byte_role = ROLE_FRAME_ST;
		end else if (c == CHAR_ETX) begin
			frame_open = 1'b0;
			r.byte_role = ROLE_FRAME_END;
		end else if (!frame_open || c == CHAR_CR) begin
			r.byte_role = ROLE_IGNORED;
		end else if (c == CHAR_LF) begin
			r.byte_role = ROLE_LINE_END;
			if (overflow || !chk_taken) begin
				r.verdict = VERD_MALFORMED;
			end else begin
				r.verdict = ({1'b0, line_check()} == chk_char) ? VERD_OK : VERD_BAD;
			end
		end else if (stored < LINE_BYTES - 1) begin
			stored++;
			r.byte_role = token_role(c);
		end
		r.computed_check = line_check();
		r.received_check = chk_char;
		if (r.byte_role == ROLE_LINE_END) begin
			clear_line();
		end
		return r;
	endfunction

	function automatic void flag_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// register writes, result comparison, then prediction of the new word
	always @(posedge clk or negedge arst_n) begin
		res_word_t want;
		if (!arst_n) begin
			sep_code = SEPARATOR_RESET;
			trail_on = TRAILING_RESET;
			frame_open = 1'b0;
			clear_line();
			expected_words.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SEPARATOR: sep_code = cfg_data;
					CFG_TRAILING:  trail_on = cfg_data[0];
					default: ;
				endcase
			end
			if (res_valid && res_ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t ns: result word with none expected, got %0h", $time,
						res_payload);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					flag_field("byte_echo", want.byte_echo, res_payload.byte_echo);
					flag_field("byte_role", 8'(want.byte_role),
						8'(res_payload.byte_role));
					flag_field("verdict", 8'(want.verdict), 8'(res_payload.verdict));
					flag_field("computed_check", 8'(want.computed_check),
						8'(res_payload.computed_check));
					flag_field("received_check", want.received_check,
						res_payload.received_check);
				end
			end
			if (rx_valid && rx_ready) begin
				expected_words.push_back(tag_byte(rx_payload.rx_byte));
			end
			outstanding <= expected_words.size();
		end
	end

endmodule

// ----- tb/tic_frame_line_checker_top_tb.sv -----
// stimulus, clock, reset and verdict for the tic frame line checker
module tic_frame_line_checker_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tflc_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 130;
	localparam int LONG_HOLD   = 80;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    outstanding;

	int         src_idle_pct = 0;
	int         snk_stall_pct = 0;
	bit         hold_req = 1'b0;
	int         hold_left = 0;
	int         items_sent = 0;
	int         quiet = 0;
	logic [6:0] cur_sep = SEPARATOR_RESET;
	logic       cur_trail = TRAILING_RESET;

	tflc_stream_if #(.payload_t(rx_word_t))  rx_ch ();
	tflc_stream_if #(.payload_t(res_word_t)) res_ch ();

	tic_frame_line_checker_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.rx       (rx_ch),
		.result   (res_ch)
	);

	tflc_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.rx_valid   (rx_ch.valid),
		.rx_ready   (rx_ch.ready),
		.rx_payload (rx_ch.payload),
		.res_valid  (res_ch.valid),
		.res_ready  (res_ch.ready),
		.res_payload(res_ch.payload),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver: random stalls, or a long hold-off when asked
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// watchdog on cycles without any word moving
	always @(posedge clk) begin
		if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet = 0;
		end else begin
			quiet = quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("tic_frame_line_checker_top verification failed");
				$finish;
			end
		end
	end

	// offer one word, idling first at random; entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.payload <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// stop offering until every expected word has come back
	task automatic drain();
		rx_ch.valid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	task automatic write_config(input logic [6:0] sep, input logic trail);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SEPARATOR;
		cfg_data <= sep;
		@(negedge clk);
		cfg_index <= CFG_TRAILING;
		cfg_data <= {6'b0, trail};
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_sep = sep;
		cur_trail = trail;
	endtask

	// printable token character, now and then one with the top bit set
	function automatic logic [7:0] token_char();
		if ($urandom_range(7) == 0) return 8'($urandom_range(8'h80, 8'hFF));
		return 8'($urandom_range(8'h21, 8'h7E));
	endfunction

	function automatic logic [7:0] gap_char();
		case ($urandom_range(9))
			0: return CHAR_TAB;
			1: return CHAR_VT;
			2: return CHAR_FF;
			default: return CHAR_SP;
		endcase
	endfunction

	// checksum character that makes a line pass under the current settings
	function automatic logic [7:0] check_for(input int sum);
		int s;
		s = sum + cur_sep + (cur_trail ? cur_sep : 0);
		return 8'((s % 64) + 32);
	endfunction

	// one line: mostly well formed, the rest cut short, nulled, broken or noise
	task automatic send_line();
		logic [7:0] text[$];
		logic [7:0] c;
		int kind;
		int n;
		int sum;
		kind = $urandom_range(99);
		sum = 0;
		if (kind >= 94) begin
			repeat ($urandom_range(1, 20)) text.push_back(8'($urandom_range(0, 255)));
			text.push_back(CHAR_LF);
		end else begin
			if ($urandom_range(9) == 0) text.push_back(gap_char());
			n = ($urandom_range(19) == 0) ? $urandom_range(32, 40) : $urandom_range(1, 8);
			repeat (n) begin
				c = token_char();
				sum += c;
				text.push_back(c);
			end
			repeat (($urandom_range(5) == 0) ? 2 : 1) text.push_back(gap_char());
			n = ($urandom_range(19) == 0) ? $urandom_range(64, 70) : $urandom_range(1, 12);
			repeat (n) begin
				c = token_char();
				sum += c;
				text.push_back(c);
			end
			text.push_back(gap_char());
			text.push_back(($urandom_range(6) == 0) ? token_char() : check_for(sum));
			// missing tokens
			if (kind >= 70 && kind < 78) begin
				repeat ($urandom_range(1, text.size() - 1)) void'(text.pop_back());
			end
			// extra text, long enough at times to fill the line
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(1, 100)) begin
					c = 8'($urandom_range(4, 255));
					text.push_back((c == CHAR_LF) ? CHAR_SP : c);
				end
			end
			if (kind >= 78 && kind < 84) text[$urandom_range(0, text.size() - 1)] = CHAR_NUL;
			if (kind >= 84 && kind < 89) begin
				// frame closes within the line, noise, then a new frame
				text.push_back(CHAR_ETX);
				repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(0, 255)));
				text.push_back(CHAR_STX);
			end else if (kind >= 89) begin
				text.push_back(CHAR_STX);
			end else begin
				if ($urandom_range(9) != 0) text.push_back(CHAR_CR);
				text.push_back(CHAR_LF);
			end
		end
		foreach (text[i]) send_byte(text[i]);
	endtask

	task automatic send_frame();
		repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
		send_byte(CHAR_STX);
		repeat ($urandom_range(1, 5)) send_line();
		send_byte(CHAR_ETX);
	endtask

	initial begin
		logic [7:0] opening[$];
		int src_pct[4];
		int snk_pct[4];
		int target;
		bit paused;
		// noise outside a frame, a passing line, a null line, a short line
		opening = '{
			CHAR_NUL, 8'hFF, CHAR_STX,
			8'h41, 8'h42, CHAR_SP, 8'h31, 8'h32, CHAR_TAB, 8'h46, CHAR_CR, CHAR_LF,
			8'h5A, CHAR_NUL, 8'h51, CHAR_LF,
			8'h4C, CHAR_VT, 8'h56, CHAR_LF,
			CHAR_ETX
		};
		src_pct = '{0, 79, 0, 18};
		snk_pct = '{0, 0, 79, 18};
		rx_ch.valid = 1'b0;
		rx_ch.payload = '0;
		res_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SEPARATOR;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int p = 0; p < PHASES; p++) begin
			src_idle_pct = src_pct[p % 4];
			snk_stall_pct = snk_pct[p % 4];
			// settings change only with the block idle
			case (p)
				0: ;
				1: begin drain(); write_config(7'd0, 1'b0); end
				2: begin drain(); write_config(7'd127, 1'b1); end
				3: begin drain(); write_config(7'd127, 1'b0); end
				4: begin drain(); write_config(7'd0, 1'b1); end
				7: begin drain(); write_config(SEPARATOR_RESET, TRAILING_RESET); end
				default: begin
					drain();
					write_config(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
				end
			endcase
			if (p == 0) begin
				foreach (opening[i]) send_byte(opening[i]);
				// receiver holds off while words keep coming
				hold_req = 1'b1;
			end
			target = items_sent + PHASE_WORDS;
			paused = 1'b0;
			while (items_sent < target) begin
				send_frame();
				if (p == 1 && !paused && items_sent > target - PHASE_WORDS / 2) begin
					drain();
					paused = 1'b1;
				end
			end
		end

		drain();
		repeat (10) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tic_frame_line_checker_top verification clean");
		end else begin
			$display("tic_frame_line_checker_top verification failed");
		end
		$finish;
	end

endmodule
